>>> design/assert_macros.svh
// Assertion helpers used by the top-level design module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication whose consequent is sampled on the next clock edge, held off while in reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> design/rgbnde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbnde_pkg;

  // Input transaction: one image column (current-row pixel and pixel below)
  typedef struct packed {
    logic [7:0] top_c0;
    logic [7:0] top_c1;
    logic [7:0] top_c2;
    logic [7:0] below_c0;
    logic [7:0] below_c1;
    logic [7:0] below_c2;
    logic       below_valid;
    logic       row_end;
  } col_t;

  // Output transaction: one result pixel
  typedef struct packed {
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic       last_of_row;
  } res_t;

  // Pixel as three channels, channel 0 at index 0
  typedef logic [2:0][7:0] pix_t;

  localparam int MODE_W     = 3;
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 2;

endpackage

`default_nettype wire

>>> design/rgb_neighbor_difference_edges_top.sv
`timescale 1ns / 1ps
`default_nettype none
// First-difference edge detector on an RGB column stream.
// Source channel (src_valid/src_ready/src_data): one column per transaction,
// the current-row pixel and the pixel below, with below_valid and row_end.
// Result channel (res_valid/res_ready/res_data): result pixels in column order.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): the mode register,
// always ready; write it only while no results are pending.
// A column is held until the column to its right arrives, then its result is
// produced; the last column of a row produces two results (held column, then
// the last column with last_of_row set). A one-column row produces one.
// A result enters the result queue with the transaction that completes it and
// is presented once the results ahead of it have left. Throughput: one column
// per cycle while src_ready is high; a row-end column after a held column puts
// two results into the three-entry queue and the result channel takes one per
// cycle, so with a ready receiver the source is held off after such a column.
// src_ready depends only on the queue fill count, so a stalled receiver fills
// the queue and then holds the source off; nothing is dropped.
// Reset (rst, synchronous) empties the queue, drops any held column and sets
// mode to pass-through.
module rgb_neighbor_difference_edges_top (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    src_valid,
  output logic                                   src_ready,
  input  wire rgbnde_pkg::col_t                  src_data,
  output logic                                   res_valid,
  input  wire                                    res_ready,
  output rgbnde_pkg::res_t                       res_data,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [rgbnde_pkg::MODE_W-1:0]           cfg_data
);

  import rgbnde_pkg::*;

  `include "assert_macros.svh"

  localparam logic [MODE_W-1:0] MODE_PASS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VERT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HORIZ = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIAG  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BEST  = 3'd4;

  logic [MODE_W-1:0] mode;
  pix_t              prev_top;
  pix_t              prev_below;
  logic              prev_bv;
  logic              have_prev;

  res_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QCNT_W-1:0] push_n;
  logic [QCNT_W-1:0] pop_n;

  logic              src_fire;
  logic              res_fire;
  pix_t              cur_top;
  pix_t              cur_below;
  res_t              res_held;
  res_t              res_last;

  // Wrap a queue pointer
  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else                               r = p + 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    if (a >= b) r = a - b;
    else        r = b - a;
    return r;
  endfunction

  // Result pixel of one column from its neighbours; absent neighbours give 0
  function automatic pix_t column_result(
    input logic [MODE_W-1:0] md,
    input pix_t top, input pix_t below, input logic below_ok,
    input pix_t right, input logic right_ok,
    input pix_t below_right, input logic diag_ok);
    pix_t       v;
    pix_t       h;
    pix_t       d;
    pix_t       r;
    logic [9:0] sv;
    logic [9:0] sh;
    logic [9:0] sd;
    sv = '0;
    sh = '0;
    sd = '0;
    for (int k = 0; k < 3; k++) begin
      v[k] = below_ok ? absdiff(top[k], below[k])       : 8'd0;
      h[k] = right_ok ? absdiff(top[k], right[k])       : 8'd0;
      d[k] = diag_ok  ? absdiff(top[k], below_right[k]) : 8'd0;
      sv = sv + 10'(v[k]);
      sh = sh + 10'(h[k]);
      sd = sd + 10'(d[k]);
    end
    case (md)
      MODE_PASS:  r = top;
      MODE_VERT:  r = v;
      MODE_HORIZ: r = h;
      MODE_DIAG:  r = d;
      MODE_BEST: begin
        if (sv >= sh && sv >= sd) r = v;
        else if (sh > sd)         r = h;
        else                      r = d;
      end
      default:    r = '0;
    endcase
    return r;
  endfunction

  assign cur_top   = {src_data.top_c2, src_data.top_c1, src_data.top_c0};
  assign cur_below = {src_data.below_c2, src_data.below_c1, src_data.below_c0};

  // Build both candidate results for the incoming column
  always_comb begin
    pix_t p_held;
    pix_t p_last;
    p_held = column_result(mode, prev_top, prev_below, prev_bv,
                           cur_top, 1'b1, cur_below, prev_bv && src_data.below_valid);
    p_last = column_result(mode, cur_top, cur_below, src_data.below_valid,
                           '0, 1'b0, '0, 1'b0);
    res_held.out_c0      = p_held[0];
    res_held.out_c1      = p_held[1];
    res_held.out_c2      = p_held[2];
    res_held.last_of_row = 1'b0;
    res_last.out_c0      = p_last[0];
    res_last.out_c1      = p_last[1];
    res_last.out_c2      = p_last[2];
    res_last.last_of_row = 1'b1;
  end

  // Handshakes; accept only when the queue can take two results
  assign cfg_ready = 1'b1;
  assign src_ready = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign res_valid = (count != '0);
  assign res_data  = queue[rptr];
  assign src_fire  = src_valid && src_ready;
  assign res_fire  = res_valid && res_ready;

  assign push_n     = src_fire ? (QCNT_W'(have_prev) + QCNT_W'(src_data.row_end)) : '0;
  assign pop_n      = QCNT_W'(res_fire);
  assign count_next = count + push_n - pop_n;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PASS;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Hold the previous column, drop it at the end of a row
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (src_fire) begin
      have_prev <= !src_data.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (src_fire) begin
      prev_top   <= cur_top;
      prev_below <= cur_below;
      prev_bv    <= src_data.below_valid;
    end
  end

  // Advance the queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (res_fire) rptr <= ptr_inc(rptr);
      if (push_n == QCNT_W'(2))      wptr <= ptr_inc(ptr_inc(wptr));
      else if (push_n == QCNT_W'(1)) wptr <= ptr_inc(wptr);
    end
  end

  // Write results in column order: held column first, then the row's last column
  always_ff @(posedge clk) begin
    if (src_fire) begin
      if (have_prev) begin
        queue[wptr] <= res_held;
        if (src_data.row_end) queue[ptr_inc(wptr)] <= res_last;
      end else if (src_data.row_end) begin
        queue[wptr] <= res_last;
      end
    end
  end

  `ASSERT_NEXT(a_count_track, src_fire,
    count == $past(count) + $past(push_n) - $past(pop_n),
    "result queue count does not follow pushes and pops")
  `ASSERT_NEXT(a_row_end_drops, src_fire && src_data.row_end, !have_prev,
    "held column survives the end of a row")
  `ASSERT_NEXT(a_double_stalls, src_fire && src_data.row_end && have_prev, !src_ready,
    "source not held off after a two-result column")
  `ASSERT_CLK(a_no_overflow, !(src_fire && count_next < count && push_n != '0 && !res_fire),
    "result queue count wrapped")

endmodule

`default_nettype wire

>>> dv/rgbnde_edge_mode_pkg.sv
`timescale 1ns / 1ps

package rgbnde_edge_mode_pkg;

  // Values of the mode register; the three top codes are unused and give black
  typedef enum logic [2:0] {
    MODE_PASS   = 3'd0,
    MODE_VERT   = 3'd1,
    MODE_HORZ   = 3'd2,
    MODE_DIAG   = 3'd3,
    MODE_STRONG = 3'd4,
    MODE_RSVD5  = 3'd5,
    MODE_RSVD6  = 3'd6,
    MODE_RSVD7  = 3'd7
  } edge_mode_e;

endpackage

>>> dv/rgbnde_edge_checker.sv
`timescale 1ns / 1ps

module rgbnde_edge_checker
  import rgbnde_pkg::*;
  import rgbnde_edge_mode_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     src_valid,
  input  wire                     src_ready,
  input  col_t                    src_data,
  input  wire                     res_valid,
  input  wire                     res_ready,
  input  res_t                    res_data,
  input  wire                     cfg_valid,
  input  wire                     cfg_ready,
  input  wire [MODE_W-1:0]        cfg_data,
  output int unsigned             mismatch_count,
  output int unsigned             pending_count
);

  // Print only the first few bad results in full
  localparam int unsigned REPORT_LIMIT = 10;

  res_t        expected_pixels[$];
  pix_t        held_top;
  pix_t        held_below;
  logic        held_below_ok;
  logic        column_held;
  edge_mode_e  cur_mode;
  int unsigned errors = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Result pixel of one column, given its neighbours and which of them exist
  function automatic pix_t edge_pixel(input edge_mode_e m, input pix_t top,
                                      input pix_t below, input logic below_ok,
                                      input pix_t right, input logic right_ok,
                                      input pix_t below_right, input logic diag_ok);
    pix_t        vert;
    pix_t        horz;
    pix_t        diag;
    int unsigned sum_v;
    int unsigned sum_h;
    int unsigned sum_d;
    sum_v = 0;
    sum_h = 0;
    sum_d = 0;
    for (int k = 0; k < 3; k++) begin
      vert[k] = below_ok ? abs_diff(top[k], below[k]) : 8'd0;
      horz[k] = right_ok ? abs_diff(top[k], right[k]) : 8'd0;
      diag[k] = diag_ok ? abs_diff(top[k], below_right[k]) : 8'd0;
      sum_v += vert[k];
      sum_h += horz[k];
      sum_d += diag[k];
    end
    case (m)
      MODE_PASS: return top;
      MODE_VERT: return vert;
      MODE_HORZ: return horz;
      MODE_DIAG: return diag;
      MODE_STRONG: begin
        // vertical wins ties, then diagonal over horizontal
        if (sum_v >= sum_h && sum_v >= sum_d) return vert;
        else if (sum_h > sum_d) return horz;
        else return diag;
      end
      default: return '0;
    endcase
  endfunction

  function automatic res_t to_result(input pix_t p, input logic last);
    res_t r;
    r.out_c0      = p[0];
    r.out_c1      = p[1];
    r.out_c2      = p[2];
    r.last_of_row = last;
    return r;
  endfunction

  task automatic flag_error(input string what, input res_t exp_r, input res_t got_r);
    if (errors < REPORT_LIMIT)
      $display("%0t: %s: expected c0=%0d c1=%0d c2=%0d last=%0b, got c0=%0d c1=%0d c2=%0d last=%0b",
               $time, what, exp_r.out_c0, exp_r.out_c1, exp_r.out_c2, exp_r.last_of_row,
               got_r.out_c0, got_r.out_c1, got_r.out_c2, got_r.last_of_row);
    errors++;
  endtask

  // Track mode, check each result against the oldest expectation, predict new ones
  always @(posedge clk) begin : track
    col_t col;
    pix_t top_px;
    pix_t below_px;
    res_t exp_r;
    if (rst) begin
      expected_pixels.delete();
      held_top      = '0;
      held_below    = '0;
      held_below_ok = 1'b0;
      column_held   = 1'b0;
      cur_mode      = MODE_PASS;
    end else begin
      if (cfg_valid && cfg_ready)
        cur_mode = edge_mode_e'(cfg_data);

      if (res_valid && res_ready) begin
        if (expected_pixels.size() == 0) begin
          flag_error("unexpected result", '0, res_data);
        end else begin
          exp_r = expected_pixels.pop_front();
          if (res_data.out_c0 !== exp_r.out_c0 || res_data.out_c1 !== exp_r.out_c1 ||
              res_data.out_c2 !== exp_r.out_c2 ||
              res_data.last_of_row !== exp_r.last_of_row)
            flag_error("wrong result", exp_r, res_data);
        end
      end

      if (src_valid && src_ready) begin
        col      = src_data;
        top_px   = {col.top_c2, col.top_c1, col.top_c0};
        below_px = {col.below_c2, col.below_c1, col.below_c0};
        // the held column now has its right-hand neighbour
        if (column_held)
          expected_pixels.push_back(to_result(
            edge_pixel(cur_mode, held_top, held_below, held_below_ok, top_px, 1'b1,
                       below_px, held_below_ok && col.below_valid), 1'b0));
        if (col.row_end) begin
          // last column: nothing to the right, then drop the held column
          expected_pixels.push_back(to_result(
            edge_pixel(cur_mode, top_px, below_px, col.below_valid, '0, 1'b0, '0, 1'b0),
            1'b1));
          column_held   = 1'b0;
          held_top      = '0;
          held_below    = '0;
          held_below_ok = 1'b0;
        end else begin
          column_held   = 1'b1;
          held_top      = top_px;
          held_below    = below_px;
          held_below_ok = col.below_valid;
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_pixels.size();
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rgbnde_pkg::*;
  import rgbnde_edge_mode_pkg::*;

  // Cycles with no transaction on any channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 96;
  localparam edge_mode_e  PHASE_MODES [PHASES] = '{
    MODE_STRONG, MODE_VERT, MODE_HORZ, MODE_DIAG, MODE_PASS, MODE_RSVD7,
    MODE_STRONG, MODE_RSVD5, MODE_HORZ, MODE_RSVD6, MODE_DIAG, MODE_STRONG
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              src_valid = 1'b0;
  logic              src_ready;
  col_t              src_data = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  res_t              res_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MODE_W-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 69;
  int unsigned stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_neighbor_difference_edges_top u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rgbnde_edge_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .src_valid      (src_valid),
    .src_ready      (src_ready),
    .src_data       (src_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_data       (res_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  // Stall the result channel at the current rate
  always @(posedge clk)
    res_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Abandon the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("rgb_neighbor_difference_edges_top: mismatch");
        $finish;
      end
    end
  end

  function automatic pix_t rand_pixel();
    pix_t p;
    for (int k = 0; k < 3; k++)
      if ($urandom_range(3) == 0) p[k] = $urandom_range(1) ? 8'hFF : 8'h00;
      else p[k] = 8'($urandom_range(255));
    return p;
  endfunction

  function automatic col_t make_col(input pix_t t, input pix_t b, input logic bv,
                                    input logic last);
    col_t c;
    c.top_c0      = t[0];
    c.top_c1      = t[1];
    c.top_c2      = t[2];
    c.below_c0    = b[0];
    c.below_c1    = b[1];
    c.below_c2    = b[2];
    c.below_valid = bv;
    c.row_end     = last;
    return c;
  endfunction

  // Step past the current edge so the count seen includes its transactions
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the mode once the source is quiet and every result has come out
  task automatic set_mode(input edge_mode_e m);
    src_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Offer one column, with a random gap first and now and then a full drain
  task automatic send_column(input col_t c);
    int unsigned gap;
    logic        drain;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 64) gap++;
    drain = ($urandom_range(79) == 0);
    if (gap != 0 || drain) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        @(posedge clk);
        wait_drained();
      end
    end
    src_valid <= 1'b1;
    src_data  <= c;
    do @(posedge clk); while (!src_ready);
  endtask

  // One row of random columns; the row below is present, absent or patchy
  task automatic send_row(input int unsigned width);
    int unsigned bv_style;
    logic        bv;
    bv_style = $urandom_range(9);
    for (int unsigned i = 0; i < width; i++) begin
      if (bv_style <= 6) bv = 1'b1;
      else if (bv_style == 7) bv = 1'b0;
      else bv = 1'($urandom_range(1));
      send_column(make_col(rand_pixel(), rand_pixel(), bv, i == width - 1));
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned width;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-column rows, white and black, in pass-through
    set_mode(MODE_PASS);
    send_column(make_col(24'hFFFFFF, 24'h000000, 1'b1, 1'b1));
    send_column(make_col(24'h000000, 24'hFFFFFF, 1'b0, 1'b1));

    // Vertical: full swings, then a last column with no row below
    set_mode(MODE_VERT);
    send_column(make_col(24'hFFFFFF, 24'h000000, 1'b1, 1'b0));
    send_column(make_col(24'h000000, 24'hFFFFFF, 1'b1, 1'b0));
    send_column(make_col(24'h563412, 24'hFFFFFF, 1'b0, 1'b1));

    // Horizontal: extremes side by side
    set_mode(MODE_HORZ);
    send_column(make_col(24'hFFFFFF, 24'h123456, 1'b1, 1'b0));
    send_column(make_col(24'h000000, 24'h654321, 1'b1, 1'b0));
    send_column(make_col(24'h80FF01, 24'hA5A5A5, 1'b1, 1'b1));

    // Diagonal: needs the row below on both the column and its right neighbour
    set_mode(MODE_DIAG);
    send_column(make_col(24'hFF00FF, 24'h00FF00, 1'b1, 1'b0));
    send_column(make_col(24'h00FF00, 24'hFFFFFF, 1'b0, 1'b0));
    send_column(make_col(24'hFFFFFF, 24'h000000, 1'b1, 1'b0));
    send_column(make_col(24'h102030, 24'hF0E0D0, 1'b1, 1'b1));

    // Strongest direction: horizontal/diagonal tie, vertical/horizontal tie, flat
    set_mode(MODE_STRONG);
    send_column(make_col(24'h646464, 24'h646464, 1'b1, 1'b0));
    send_column(make_col(24'h646400, 24'h640064, 1'b1, 1'b1));
    send_column(make_col(24'h323232, 24'h323200, 1'b1, 1'b0));
    send_column(make_col(24'h320032, 24'h323232, 1'b1, 1'b1));
    send_column(make_col(24'h777777, 24'h777777, 1'b1, 1'b0));
    send_column(make_col(24'h777777, 24'h777777, 1'b1, 1'b1));

    // Unused modes give black
    set_mode(MODE_RSVD5);
    send_column(make_col(24'hFFFFFF, 24'h000000, 1'b1, 1'b0));
    send_column(make_col(24'h00FF00, 24'hFF00FF, 1'b1, 1'b1));
    set_mode(MODE_RSVD7);
    send_column(make_col(24'hABCDEF, 24'h000000, 1'b1, 1'b1));

    // Random rows, changing mode and stall rates between phases
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) begin
        tx_idle_pct = 11;
        rx_idle_pct = 69;
      end else if (p < 2 * PHASES / 3) begin
        tx_idle_pct = 69;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_mode(PHASE_MODES[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        width = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
        send_row(width);
        sent += width;
      end
    end

    // Let the last results out, then give the verdict
    src_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("rgb_neighbor_difference_edges_top: match");
    else
      $display("rgb_neighbor_difference_edges_top: mismatch");
    $finish;
  end

endmodule
